[hw/rtl/position_weighted_site_checksum_macros.svh]
// Assertion helpers shared by the checksum block
`ifndef POSITION_WEIGHTED_SITE_CHECKSUM_MACROS_SVH
`define POSITION_WEIGHTED_SITE_CHECKSUM_MACROS_SVH

// Check that a condition implies a property on the same edge
`define PWSC_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies a property on the next edge
`define PWSC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[hw/rtl/pwsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_pkg
// Shared types, constants and helpers of the site checksum block.
// ----------------------------------------------------------------------------
package pwsc_pkg;

  localparam int unsigned ExtentBits = 12;
  localparam int unsigned NumDims    = 5;
  localparam int unsigned DivCount   = 32;
  localparam int unsigned DivCntW    = $clog2(DivCount + 1);
  localparam int unsigned DimW       = 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BYTE_SWAP     = 3'd0,
    CFG_FORMAT_KNOWN  = 3'd1,
    CFG_FIVE_DIM      = 3'd2,
    CFG_LOCAL_EXTENTS = 3'd3,
    CFG_NODE_COORDS   = 3'd4,
    CFG_NODE_GRID     = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_COMB_INIT,
    ST_COMB_MUL1,
    ST_COMB_MUL2,
    ST_FINAL_MUL,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            accum;     // take an input word
    logic            latch_id;  // capture site id for the last word
    logic            div_load;  // load divider with current dimension
    logic            div_step;  // one restoring step
    logic            div_store; // store remainder part and quotient
    logic            comb_init; // start recombination
    logic            comb_mul1; // g * grid
    logic            comb_mul2; // * extent + part
    logic            fin_mul;   // sum * (gid + 1)
    logic [DimW-1:0] dim;
  } cmd_t;

  typedef struct packed {
    logic use_given;
  } sts_t;

  function automatic logic [31:0] reverse_bytes(input logic [31:0] w);
    reverse_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

[hw/rtl/pwsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_datapath
// Weighted sum, serial divider, global id recombination and result multiply.
// ----------------------------------------------------------------------------
module pwsc_datapath
  import pwsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        byte_swap_i,
  input  logic        format_known_i,
  input  logic        five_dim_i,
  input  logic [59:0] local_extents_i,
  input  logic [59:0] node_coords_i,
  input  logic [47:0] node_grid_i,
  input  logic [31:0] data_word_i,
  input  logic [31:0] site_index_i,
  input  logic [30:0] given_global_i,
  output logic [31:0] result_o
);

  logic [31:0] sum_q, sum_d, pos_q, pos_d;
  logic [31:0] sid_q, sid_d;
  logic [30:0] given_q;
  logic        use_given_q;
  logic [31:0] quo_q, quo_d, rem_q, rem_d;
  logic [31:0] part_q [NumDims];
  logic [31:0] g_q, g_d, res_q;
  logic [31:0] word, pos_inc;
  logic [ExtentBits-1:0] ext, crd, grd;
  logic [31:0] ext32;
  logic [32:0] trial;

  // Select dimension fields; zero extent counts as one
  always_comb begin
    ext = local_extents_i[cmd_i.dim*ExtentBits +: ExtentBits];
    crd = node_coords_i[cmd_i.dim*ExtentBits +: ExtentBits];
    grd = (cmd_i.dim < DimW'(4)) ? node_grid_i[cmd_i.dim[1:0]*ExtentBits +: ExtentBits]
                                 : '0;
    if (ext == '0) ext = ExtentBits'(1);
    ext32 = 32'(ext);
  end

  assign word    = byte_swap_i ? reverse_bytes(data_word_i) : data_word_i;
  assign pos_inc = pos_q + 32'd1;
  assign trial   = {rem_q, quo_q[31]} - {1'b0, ext32};

  // Advance sum and position, clear after the result
  always_comb begin
    sum_d = sum_q;
    pos_d = pos_q;
    if (cmd_i.accum) begin
      pos_d = pos_inc;
      sum_d = sum_q + 32'(word * pos_inc);
    end
    if (cmd_i.fin_mul) begin
      sum_d = '0;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      pos_q <= '0;
      use_given_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      pos_q <= pos_d;
      if (cmd_i.latch_id) use_given_q <= site_index_i[31];
    end
  end

  // Restoring divider, one quotient bit a cycle
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    sid_d = sid_q;
    if (cmd_i.latch_id) sid_d = site_index_i;
    if (cmd_i.div_load) begin
      quo_d = sid_q;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
    end else if (cmd_i.div_store) begin
      sid_d = quo_q;
    end
  end

  // Recombination over global extents, one multiply per cycle
  always_comb begin
    g_d = g_q;
    if (cmd_i.comb_init) g_d = five_dim_i ? part_q[4] : '0;
    else if (cmd_i.comb_mul1) g_d = 32'(g_q * 32'(grd));
    else if (cmd_i.comb_mul2) g_d = 32'(g_q * ext32) + part_q[cmd_i.dim];
  end

  always_ff @(posedge clk_i) begin
    sid_q <= sid_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    g_q   <= g_d;
    if (cmd_i.latch_id) given_q <= given_global_i;
    if (cmd_i.div_store) part_q[cmd_i.dim] <= rem_q + 32'(ext32 * 32'(crd));
    if (cmd_i.fin_mul) begin
      res_q <= format_known_i
             ? 32'(sum_q * ((use_given_q ? {1'b0, given_q} : g_q) + 32'd1)) : '0;
    end
  end

  assign sts_o.use_given = use_given_q;
  assign result_o        = res_q;

endmodule

[hw/rtl/pwsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_ctrl
// Sequencer: accumulate words, divide per dimension and recombine (or use the given id), emit result.
// ----------------------------------------------------------------------------
`include "position_weighted_site_checksum_macros.svh"
module pwsc_ctrl
  import pwsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_word_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e              state_q, state_d;
  logic [DimW-1:0]     dim_q, dim_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                take;

  assign take = in_valid_i && (state_q == ST_ACCUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      dim_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      dim_q   <= dim_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    dim_d       = dim_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.dim   = dim_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        in_stall_o = 1'b0;
        if (take) begin
          cmd_o.accum = 1'b1;
          if (last_word_i) begin
            cmd_o.latch_id = 1'b1;
            dim_d   = '0;
            state_d = ST_DIV_START;
          end
        end
      end
      ST_DIV_START: begin
        if (sts_i.use_given) begin
          state_d = ST_FINAL_MUL;
        end else begin
          cmd_o.div_load = 1'b1;
          cnt_d   = '0;
          state_d = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivCount - 1)) state_d = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        cmd_o.div_store = 1'b1;
        if (dim_q == DimW'(NumDims - 1)) begin
          state_d = ST_COMB_INIT;
        end else begin
          dim_d   = dim_q + DimW'(1);
          state_d = ST_DIV_START;
        end
      end
      ST_COMB_INIT: begin
        cmd_o.comb_init = 1'b1;
        dim_d   = DimW'(3);
        state_d = ST_COMB_MUL1;
      end
      ST_COMB_MUL1: begin
        cmd_o.comb_mul1 = 1'b1;
        state_d = ST_COMB_MUL2;
      end
      ST_COMB_MUL2: begin
        cmd_o.comb_mul2 = 1'b1;
        if (dim_q == '0) begin
          state_d = ST_FINAL_MUL;
        end else begin
          dim_d   = dim_q - DimW'(1);
          state_d = ST_COMB_MUL1;
        end
      end
      ST_FINAL_MUL: begin
        cmd_o.fin_mul = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  `PWSC_ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, state_q != ST_ACCUM, in_stall_o, "input taken while busy")
  `PWSC_ASSERT_NEXT(a_last_starts, clk_i, rst_ni, take && last_word_i, state_q == ST_DIV_START, "last word did not start id work")
  `PWSC_ASSERT_NEXT(a_fin_to_out, clk_i, rst_ni, cmd_o.fin_mul, out_valid_o, "result not presented")
  `PWSC_ASSERT_IMPL(a_dim_range, clk_i, rst_ni, 1'b1, dim_q < DimW'(NumDims), "dimension out of range")

endmodule

[hw/rtl/position_weighted_site_checksum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_weighted_site_checksum
// Position-weighted checksum of lattice site records with global site id.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) transfers one record word per cycle
//   while in_stall is low, with last_word, site_index and given_global.
//   Words that are not last give no result.
//   On a last word the block stalls input while it computes the global id:
//   five 32-step serial divisions, one recombination setup, eight
//   recombination multiplies and one final multiply, after which out_valid
//   rises; with a negative site_index it skips to the final multiply.
//   The result is then held on site_checksum_o with out_valid until the
//   receiver drops out_stall; the block waits meanwhile and takes no input.
//   Input is taken again in the cycle after the result transfer.
//   The serial divider sets the long latency.
//   Reset clears the running sum and position and loads the default
//   configuration. Write configuration only while idle.
// ----------------------------------------------------------------------------
module position_weighted_site_checksum
  import pwsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [59:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word_i,
  input  logic        last_word_i,
  input  logic signed [31:0] site_index_i,
  input  logic [30:0] given_global_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] site_checksum_o
);

  logic        byte_swap_q, format_known_q, five_dim_q;
  logic [59:0] local_extents_q, node_coords_q;
  logic [47:0] node_grid_q;
  cmd_t        cmd;
  sts_t        sts;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_swap_q     <= 1'b0;
      format_known_q  <= 1'b1;
      five_dim_q      <= 1'b0;
      local_extents_q <= 60'h001001001001001;
      node_coords_q   <= '0;
      node_grid_q     <= 48'h001001001001;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BYTE_SWAP:     byte_swap_q     <= cfg_data_i[0];
        CFG_FORMAT_KNOWN:  format_known_q  <= cfg_data_i[0];
        CFG_FIVE_DIM:      five_dim_q      <= cfg_data_i[0];
        CFG_LOCAL_EXTENTS: local_extents_q <= cfg_data_i;
        CFG_NODE_COORDS:   node_coords_q   <= cfg_data_i;
        CFG_NODE_GRID:     node_grid_q     <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  pwsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .last_word_i (last_word_i),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pwsc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .byte_swap_i     (byte_swap_q),
    .format_known_i  (format_known_q),
    .five_dim_i      (five_dim_q),
    .local_extents_i (local_extents_q),
    .node_coords_i   (node_coords_q),
    .node_grid_i     (node_grid_q),
    .data_word_i     (data_word_i),
    .site_index_i    (site_index_i),
    .given_global_i  (given_global_i),
    .result_o        (site_checksum_o)
  );

endmodule
